// ----- hw/rtl/rc4_stream_cipher_defines.svh -----
// assertion macros for the rc4 stream cipher checker
// no dependencies; included by the checker file only
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// consequent checked in the same cycle
`define RC4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rc4_pkg.sv -----
// shared types and constants for the rc4 stream cipher
// no dependencies
`default_nettype none

package rc4_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_BYTES     = 4 * KEY_WORDS;
    localparam int KEY_SEL_W     = $clog2(KEY_BYTES);
    localparam int LEN_W         = 6;
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int TABLE_DEPTH   = 256;
    localparam int BYTE_W        = 8;

    localparam logic [KEY_LEN_W-1:0]  KEY_LENGTH_RST = 5'd3;
    localparam logic [CFG_DATA_W-1:0] KEY_WORD_0_RST = 32'h006C_6A77;
    localparam logic [CFG_DATA_W-1:0] KEY_WORD_RST   = 32'h0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_READ,
        ST_KS_MIX,
        ST_KS_WR_K,
        ST_KS_WR_J,
        ST_GEN_INC,
        ST_GEN_MIX,
        ST_GEN_SWAP,
        ST_GEN_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_FILL,
        OP_KS_READ,
        OP_KS_MIX,
        OP_KS_WR_K,
        OP_KS_WR_J,
        OP_GEN_INC,
        OP_GEN_MIX,
        OP_GEN_SWAP,
        OP_GEN_OUT
    } t_dp_op;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hw/rtl/rc4_stream_cipher.sv -----
// RC4 stream cipher. Each transfer on the input channel carries one byte and
// yields one byte on the output channel, the input XOR the next keystream
// byte, so the same block encrypts and decrypts. A byte with start_of_message
// set, and the first byte after reset, first runs the key schedule from the
// key registers and restarts the keystream. The permutation table is a single
// 256 x 8 memory with one read and one write port, and each byte needs two
// reads, two swap writes and one result read in it (GEN_INC, GEN_MIX,
// GEN_SWAP, GEN_OUT); no new byte is taken before GEN_OUT. The key schedule
// fills the table, then runs KS_READ, KS_MIX, KS_WR_K and KS_WR_J per mixing
// step, with the input stalled. Key registers may be written only while the
// block is idle; a new key is used from the next key schedule on.
// depends on rc4_pkg, rc4_ctrl and rc4_datapath
`default_nettype none

module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rc4_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [rc4_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire logic                           i_start_of_message,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [rc4_pkg::BYTE_W-1:0]     o_cipher_byte
);

    rc4_pkg::t_dp_cmd    w_cmd;
    rc4_pkg::t_dp_status w_status;

    rc4_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .i_start_of_message (i_start_of_message),
        .o_stall            (o_stall),
        .i_status           (w_status),
        .o_cmd              (w_cmd)
    );

    rc4_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_cipher_byte (o_cipher_byte)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rc4_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rc4_datapath.sv -----
// rc4 datapath: key registers, indices, permutation table and output register
// depends on rc4_pkg and rc4_ram
`default_nettype none

module rc4_datapath #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rc4_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [rc4_pkg::BYTE_W-1:0]        i_data_byte,
    input  wire logic                              i_stall,
    input  wire rc4_pkg::t_dp_cmd                  i_cmd,
    output rc4_pkg::t_dp_status                    o_status,
    output logic                                   o_valid,
    output logic      [rc4_pkg::BYTE_W-1:0]        o_cipher_byte
);

    localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int BW  = rc4_pkg::BYTE_W;
    localparam int LW  = rc4_pkg::LEN_W;

    // configuration registers
    logic [rc4_pkg::KEY_LEN_W-1:0]  r_key_length;
    logic [rc4_pkg::CFG_DATA_W-1:0] r_key_word [rc4_pkg::KEY_WORDS];

    logic [BW-1:0]  r_i, n_i;
    logic [BW-1:0]  r_j, n_j;
    logic [BW-1:0]  r_si, n_si;
    logic [BW-1:0]  r_sj, n_sj;
    logic [BW-1:0]  r_t, n_t;
    logic [KIW-1:0] r_kidx, n_kidx;
    logic [BW-1:0]  r_data;
    logic [BW-1:0]  r_out, n_out;
    logic           r_out_valid;
    logic           w_load_out;

    logic [BW-1:0] w_key_bytes [rc4_pkg::KEY_BYTES];
    logic [LW-1:0] w_len_eff;
    logic [LW-1:0] w_kidx_ext;
    logic [BW-1:0] w_key_byte;
    logic [BW-1:0] w_fwd;
    logic [BW-1:0] w_sum;

    logic          w_we;
    logic [BW-1:0] w_waddr;
    logic [BW-1:0] w_wdata;
    logic [BW-1:0] w_raddr;
    logic [BW-1:0] w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length  <= rc4_pkg::KEY_LENGTH_RST;
            r_key_word[0] <= rc4_pkg::KEY_WORD_0_RST;
            r_key_word[1] <= rc4_pkg::KEY_WORD_RST;
            r_key_word[2] <= rc4_pkg::KEY_WORD_RST;
            r_key_word[3] <= rc4_pkg::KEY_WORD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rc4_pkg::CFG_KEY_LENGTH: begin
                    r_key_length <= i_cfg_data[rc4_pkg::KEY_LEN_W-1:0];
                end
                rc4_pkg::CFG_KEY_WORD_0: r_key_word[0] <= i_cfg_data;
                rc4_pkg::CFG_KEY_WORD_1: r_key_word[1] <= i_cfg_data;
                rc4_pkg::CFG_KEY_WORD_2: r_key_word[2] <= i_cfg_data;
                rc4_pkg::CFG_KEY_WORD_3: r_key_word[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < rc4_pkg::KEY_BYTES; g++) begin : g_key_bytes
        assign w_key_bytes[g] = r_key_word[g / 4][8 * (g % 4) +: 8];
    end

    // zero length acts as one, longer than the store saturates
    always_comb begin
        if (r_key_length == '0) begin
            w_len_eff = LW'(1);
        end else if (LW'(r_key_length) > LW'(MAX_KEY_BYTES)) begin
            w_len_eff = LW'(MAX_KEY_BYTES);
        end else begin
            w_len_eff = LW'(r_key_length);
        end
    end

    assign w_kidx_ext = LW'(r_kidx);
    assign w_key_byte = (w_kidx_ext < LW'(rc4_pkg::KEY_BYTES))
                      ? w_key_bytes[w_kidx_ext[rc4_pkg::KEY_SEL_W-1:0]] : '0;

    // the table read for the result may race the swap writes, so patch it
    always_comb begin
        if (r_t == r_j) begin
            w_fwd = r_si;
        end else if (r_t == r_i) begin
            w_fwd = r_sj;
        end else begin
            w_fwd = w_q;
        end
    end

    always_comb begin
        n_i        = r_i;
        n_j        = r_j;
        n_si       = r_si;
        n_sj       = r_sj;
        n_t        = r_t;
        n_kidx     = r_kidx;
        n_out      = r_out;
        w_load_out = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_i;
        w_wdata    = r_i;
        w_raddr    = r_t;
        w_sum      = '0;
        case (i_cmd.op)
            rc4_pkg::OP_CLEAR: begin
                n_i    = '0;
                n_j    = '0;
                n_kidx = '0;
            end
            rc4_pkg::OP_FILL: begin
                w_we = 1'b1;
                n_i  = BW'(r_i + 1'b1);
            end
            rc4_pkg::OP_KS_READ: begin
                w_raddr = r_i;
            end
            rc4_pkg::OP_KS_MIX: begin
                w_sum   = BW'(r_j + w_q + w_key_byte);
                n_si    = w_q;
                n_j     = w_sum;
                w_raddr = w_sum;
            end
            rc4_pkg::OP_KS_WR_K: begin
                w_we    = 1'b1;
                w_wdata = w_q;
            end
            rc4_pkg::OP_KS_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
                n_i     = BW'(r_i + 1'b1);
                n_kidx  = (w_kidx_ext == LW'(w_len_eff - 1'b1)) ? '0 : KIW'(r_kidx + 1'b1);
                if (r_i == '1) begin
                    n_j = '0;
                end
            end
            rc4_pkg::OP_GEN_INC: begin
                w_sum   = BW'(r_i + 1'b1);
                n_i     = w_sum;
                w_raddr = w_sum;
            end
            rc4_pkg::OP_GEN_MIX: begin
                w_sum   = BW'(r_j + w_q);
                n_si    = w_q;
                n_j     = w_sum;
                w_raddr = w_sum;
            end
            rc4_pkg::OP_GEN_SWAP: begin
                w_sum   = BW'(r_si + w_q);
                n_sj    = w_q;
                n_t     = w_sum;
                w_we    = 1'b1;
                w_wdata = w_q;
                w_raddr = w_sum;
            end
            rc4_pkg::OP_GEN_OUT: begin
                w_we       = 1'b1;
                w_waddr    = r_j;
                w_wdata    = r_si;
                n_out      = r_data ^ w_fwd;
                w_load_out = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_kidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_i    <= n_i;
            r_j    <= n_j;
            r_kidx <= n_kidx;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_si  <= n_si;
        r_sj  <= n_sj;
        r_t   <= n_t;
        r_out <= n_out;
        if (i_cmd.capture) begin
            r_data <= i_data_byte;
        end
    end

    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (rc4_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign o_status.last     = (r_i == '1);
    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_cipher_byte     = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/rc4_ctrl.sv -----
// rc4 controller: sequences the key schedule and keystream steps
// depends on rc4_pkg
`default_nettype none

module rc4_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_start_of_message,
    output logic                     o_stall,
    input  wire rc4_pkg::t_dp_status i_status,
    output rc4_pkg::t_dp_cmd         o_cmd
);

    rc4_pkg::t_state r_state, n_state;
    logic            r_scheduled, n_scheduled;
    logic            w_need_sched;

    // first byte after reset schedules even without the start flag
    assign w_need_sched = i_start_of_message || !r_scheduled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc4_pkg::ST_IDLE;
            r_scheduled <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scheduled <= n_scheduled;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_scheduled = r_scheduled;
        case (r_state)
            rc4_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = w_need_sched ? rc4_pkg::ST_FILL : rc4_pkg::ST_GEN_INC;
                end
            end
            rc4_pkg::ST_FILL: begin
                if (i_status.last) begin
                    n_state = rc4_pkg::ST_KS_READ;
                end
            end
            rc4_pkg::ST_KS_READ: n_state = rc4_pkg::ST_KS_MIX;
            rc4_pkg::ST_KS_MIX:  n_state = rc4_pkg::ST_KS_WR_K;
            rc4_pkg::ST_KS_WR_K: n_state = rc4_pkg::ST_KS_WR_J;
            rc4_pkg::ST_KS_WR_J: begin
                if (i_status.last) begin
                    n_state     = rc4_pkg::ST_GEN_INC;
                    n_scheduled = 1'b1;
                end else begin
                    n_state = rc4_pkg::ST_KS_READ;
                end
            end
            rc4_pkg::ST_GEN_INC:  n_state = rc4_pkg::ST_GEN_MIX;
            rc4_pkg::ST_GEN_MIX:  n_state = rc4_pkg::ST_GEN_SWAP;
            rc4_pkg::ST_GEN_SWAP: n_state = rc4_pkg::ST_GEN_OUT;
            rc4_pkg::ST_GEN_OUT: begin
                if (i_status.out_free) begin
                    n_state = rc4_pkg::ST_IDLE;
                end
            end
            default: n_state = rc4_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.capture = 1'b0;
        o_cmd.op      = rc4_pkg::OP_NONE;
        o_stall       = 1'b1;
        case (r_state)
            rc4_pkg::ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
                if (i_valid && w_need_sched) begin
                    o_cmd.op = rc4_pkg::OP_CLEAR;
                end
            end
            rc4_pkg::ST_FILL:     o_cmd.op = rc4_pkg::OP_FILL;
            rc4_pkg::ST_KS_READ:  o_cmd.op = rc4_pkg::OP_KS_READ;
            rc4_pkg::ST_KS_MIX:   o_cmd.op = rc4_pkg::OP_KS_MIX;
            rc4_pkg::ST_KS_WR_K:  o_cmd.op = rc4_pkg::OP_KS_WR_K;
            rc4_pkg::ST_KS_WR_J:  o_cmd.op = rc4_pkg::OP_KS_WR_J;
            rc4_pkg::ST_GEN_INC:  o_cmd.op = rc4_pkg::OP_GEN_INC;
            rc4_pkg::ST_GEN_MIX:  o_cmd.op = rc4_pkg::OP_GEN_MIX;
            rc4_pkg::ST_GEN_SWAP: o_cmd.op = rc4_pkg::OP_GEN_SWAP;
            rc4_pkg::ST_GEN_OUT: begin
                // hold the swap write and result until the output register frees
                if (i_status.out_free) begin
                    o_cmd.op = rc4_pkg::OP_GEN_OUT;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rc4_checker.sv -----
// port-level checks for the rc4 stream cipher, bound to the top level
// depends on rc4_stream_cipher_defines.svh and rc4_pkg
`default_nettype none
`include "rc4_stream_cipher_defines.svh"

module rc4_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [rc4_pkg::BYTE_W-1:0] o_cipher_byte
);

    // one byte in flight: the input closes right after a transfer
    `RC4_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input open after transfer")

    // a result never appears the cycle after its byte arrives
    `RC4_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_valid && !o_stall, !$rose(o_valid), "result too early")

    // a stalled result holds
    `RC4_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_cipher_byte), "stalled result changed")

endmodule

bind rc4_stream_cipher rc4_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_cipher_byte (o_cipher_byte)
);

`default_nettype wire

// ----- tb/sv/rc4_keystream_checker.sv -----
`timescale 1ns / 100ps
// rc4 keystream checker: follows register writes and both transfer channels,
// predicts every cipher byte and compares the results in order
// depends on rc4_pkg
module rc4_keystream_checker
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_start_of_message,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [BYTE_W-1:0]     i_cipher_byte,
    input  logic                  i_drain_done,
    output int                    o_pending,
    output int                    o_mismatches
);

    localparam int MAX_REPORTS = 20;

    logic [KEY_LEN_W-1:0]  key_length;
    logic [CFG_DATA_W-1:0] key_words [KEY_WORDS];
    logic [BYTE_W-1:0]     perm [TABLE_DEPTH];
    logic [BYTE_W-1:0]     idx_i;
    logic [BYTE_W-1:0]     idx_j;
    logic                  keyed;
    logic [BYTE_W-1:0]     expected_cipher [$];
    logic [BYTE_W-1:0]     want;
    int                    mismatches = 0;
    int                    results_seen = 0;
    bit                    drain_checked = 1'b0;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
        keyed        = 1'b0;
        idx_i        = '0;
        idx_j        = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) perm[k] = '0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // advances the keystream by one byte, rerunning the key schedule first
    // on a start of message or when no schedule has run since reset
    function automatic logic [BYTE_W-1:0] rc4_encipher(input logic [BYTE_W-1:0] data,
                                                       input logic som);
        int unsigned       len;
        int unsigned       n;
        int                k;
        logic [BYTE_W-1:0] j;
        logic [BYTE_W-1:0] si;
        logic [BYTE_W-1:0] sj;
        logic [BYTE_W-1:0] held;
        if (som || !keyed) begin
            len = key_length;
            if (len == 0) len = 1;
            if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
            for (k = 0; k < TABLE_DEPTH; k++) perm[k] = BYTE_W'(k);
            j = '0;
            for (k = 0; k < TABLE_DEPTH; k++) begin
                n = k % len;
                j = j + perm[k] + key_words[n / 4][8 * (n % 4) +: 8];
                held    = perm[k];
                perm[k] = perm[j];
                perm[j] = held;
            end
            idx_i = '0;
            idx_j = '0;
            keyed = 1'b1;
        end
        idx_i = idx_i + 1'b1;
        idx_j = idx_j + perm[idx_i];
        si = perm[idx_i];
        sj = perm[idx_j];
        perm[idx_i] = sj;
        perm[idx_j] = si;
        return data ^ perm[BYTE_W'(si + sj)];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_length   = KEY_LENGTH_RST;
            key_words[0] = KEY_WORD_0_RST;
            for (int w = 1; w < KEY_WORDS; w++) key_words[w] = KEY_WORD_RST;
            keyed = 1'b0;
            idx_i = '0;
            idx_j = '0;
            expected_cipher.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_cipher.size() == 0) begin
                    report_mismatch($sformatf("cipher byte %02h with none expected",
                                              i_cipher_byte));
                end else begin
                    want = expected_cipher.pop_front();
                    if (i_cipher_byte !== want)
                        report_mismatch($sformatf("result %0d: cipher byte %02h, expected %02h",
                                                  results_seen, i_cipher_byte, want));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_cipher.push_back(rc4_encipher(i_data_byte, i_start_of_message));
            // key registers only feed the next schedule
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_LENGTH: key_length   = i_cfg_data[KEY_LEN_W-1:0];
                    CFG_KEY_WORD_0: key_words[0] = i_cfg_data;
                    CFG_KEY_WORD_1: key_words[1] = i_cfg_data;
                    CFG_KEY_WORD_2: key_words[2] = i_cfg_data;
                    CFG_KEY_WORD_3: key_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_drain_done && !drain_checked) begin
                drain_checked = 1'b1;
                if (expected_cipher.size() != 0)
                    report_mismatch($sformatf("%0d cipher bytes never arrived",
                                              expected_cipher.size()));
            end
        end
        o_pending    <= expected_cipher.size();
        o_mismatches <= mismatches;
    end

endmodule

// ----- tb/sv/rc4_stream_cipher_tb.sv -----
`timescale 1ns / 100ps
// top of the rc4 stream cipher testbench: clock, reset, register writes and
// byte stimulus with random idling on both channels; the verdict comes from
// rc4_keystream_checker; depends on rc4_pkg, rc4_stream_cipher and the checker
module rc4_stream_cipher_tb;
    import rc4_pkg::*;

    localparam int RANDOM_BYTES    = 1930;
    localparam int IDLE_PCT        = 38;
    localparam int QUIET_PHASE     = 1;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  i_start_of_message;
    logic                  o_valid;
    logic                  i_stall;
    logic [BYTE_W-1:0]     o_cipher_byte;

    logic drain_done;
    int   pending;
    int   mismatches;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_cycles;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   messages = 0;
    int   key_settings = 0;

    rc4_stream_cipher DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_start_of_message (i_start_of_message),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_cipher_byte      (o_cipher_byte)
    );

    rc4_keystream_checker keystream_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_data_byte        (i_data_byte),
        .i_start_of_message (i_start_of_message),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_cipher_byte      (o_cipher_byte),
        .i_drain_done       (drain_done),
        .o_pending          (pending),
        .o_mismatches       (mismatches)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiving side: random stalls, or one long hold-off when asked for
    always begin
        @(negedge i_clk);
        if (hold_off_cycles != 0) begin
            i_stall <= 1'b1;
            repeat (hold_off_cycles) @(negedge i_clk);
            hold_off_cycles = 0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic som);
        int gap;
        @(negedge i_clk);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            gap = $urandom_range(3, 1);
            repeat (gap) @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_data_byte        <= data;
        i_start_of_message <= som;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        if (som) messages++;
    endtask

    // sender goes quiet until every predicted byte has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_key_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int            phase;
        int            msg_count;
        int            msg_len;
        int            m;
        int            b;
        int            w;
        int            idx;
        int            random_sent;
        int unsigned   key_len;
        logic          som_first;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        i_valid            = 1'b0;
        i_data_byte        = '0;
        i_start_of_message = 1'b0;
        i_stall            = 1'b0;
        drain_done         = 1'b0;
        send_idle_pct      = IDLE_PCT;
        recv_stall_pct     = IDLE_PCT;
        hold_off_cycles    = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key; the very first byte must trigger a schedule on its own
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h7F, 1'b0);
        key_settings++;

        // zero key length behaves as a single key byte
        wait_for_results();
        cfg_write(CFG_KEY_LENGTH, 32'd0);
        cfg_write(CFG_KEY_WORD_0, 32'hFFFF_FFFF);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        key_settings++;

        // longest key, all ones
        wait_for_results();
        cfg_write(CFG_KEY_LENGTH, 32'd16);
        cfg_write(CFG_KEY_WORD_1, 32'hFFFF_FFFF);
        cfg_write(CFG_KEY_WORD_2, 32'hFFFF_FFFF);
        cfg_write(CFG_KEY_WORD_3, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        key_settings++;

        // length above the maximum saturates, all-zero key
        wait_for_results();
        cfg_write(CFG_KEY_LENGTH, 32'd31);
        for (w = 0; w < KEY_WORDS; w++) cfg_write(CFG_IDX_W'(CFG_KEY_WORD_0 + w), '0);
        send_byte(8'h12, 1'b1);
        send_byte(8'hED, 1'b0);
        key_settings++;

        // writes past the last register must change nothing; then length and key are all rewritten
        wait_for_results();
        for (idx = CFG_KEY_WORD_3 + 1; idx < (1 << CFG_IDX_W); idx++)
            cfg_write(CFG_IDX_W'(idx), $urandom());
        cfg_write(CFG_KEY_LENGTH, 32'd17);
        for (w = 0; w < KEY_WORDS; w++)
            cfg_write(CFG_IDX_W'(CFG_KEY_WORD_0 + w), $urandom());
        send_byte(8'h01, 1'b1);
        send_byte(8'hFE, 1'b0);
        key_settings++;

        // new key mid-message: old keystream carries on until the next start
        wait_for_results();
        cfg_write(CFG_KEY_LENGTH, 32'd5);
        cfg_write(CFG_KEY_WORD_0, 32'hA5C3_0F96);
        cfg_write(CFG_KEY_WORD_1, 32'h0000_0042);
        send_byte(8'h40, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h99, 1'b1);
        key_settings++;

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_BYTES) begin
            wait_for_results();
            if (phase == 0 || $urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0:       key_len = 0;
                    1:       key_len = $urandom_range(31, 17);
                    2:       key_len = 16;
                    3:       key_len = 1;
                    default: key_len = $urandom_range(16, 1);
                endcase
                // junk in the unused upper bits of the length write
                cfg_write(CFG_KEY_LENGTH, ($urandom() & ~32'h1F) | key_len);
            end
            for (w = 0; w < KEY_WORDS; w++)
                if ($urandom_range(1) == 1)
                    cfg_write(CFG_IDX_W'(CFG_KEY_WORD_0 + w), random_key_word());
            if ($urandom_range(7) == 0)
                cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_KEY_WORD_3 + 1)),
                          $urandom());
            key_settings++;

            send_idle_pct  = (phase == QUIET_PHASE) ? 0 : IDLE_PCT;
            recv_stall_pct = (phase == QUIET_PHASE) ? 0 : IDLE_PCT;

            // output held off while bytes keep coming, so the block backs up
            if (phase == HOLD_PHASE) begin
                hold_off_cycles = HOLD_OFF_CYCLES;
                for (b = 0; b < 40; b++) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
                random_sent += 40;
            end

            msg_count = $urandom_range(6, 2);
            for (m = 0; m < msg_count; m++) begin
                case ($urandom_range(19))
                    0:          msg_len = $urandom_range(300, 257);
                    1, 2, 3, 4: msg_len = $urandom_range(80, 21);
                    default:    msg_len = $urandom_range(20, 1);
                endcase
                // sometimes carry the keystream on across the key change
                som_first = !(m == 0 && $urandom_range(3) == 0);
                for (b = 0; b < msg_len; b++)
                    send_byte(BYTE_W'($urandom_range(255)), som_first && b == 0);
                random_sent += msg_len;
            end
            phase++;
        end

        wait_for_results();
        drain_done <= 1'b1;
        repeat (2) @(negedge i_clk);

        $display("covered %0d bytes, %0d message starts, %0d key settings in %0d cycles",
                 bytes_sent, messages, key_settings, cycle_count);
        $display("key lengths 0 to 31, spare register writes, mid-stream key changes, %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
